// ===== rtl/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types for the LZSS window decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int POS_W       = $clog2(WINDOW_SIZE);
	localparam int BYTE_W      = 8;
	localparam int FLAG_CNT_W  = 4;
	localparam int MIN_MATCH_DEF = 3;

	localparam logic [BYTE_W-1:0]     SPACE_FILL   = 8'h20;
	localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE = 4'd8;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_WR
	} lzwd_state_t;

endpackage

// ===== rtl/lzwd_in_if.sv =====
// ----------------------------------------------------------------------------
// lzwd_in_if
// Compressed byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface lzwd_in_if
	import lzwd_pkg::*;
;
	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/lzwd_out_if.sv =====
// ----------------------------------------------------------------------------
// lzwd_out_if
// Decompressed byte channel: valid/ready handshake, byte plus last marker.
// ----------------------------------------------------------------------------
interface lzwd_out_if
	import lzwd_pkg::*;
;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/lzwd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lzss_window_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_window_decompressor
// Flag bytes and the first byte of a match give no output.
// A literal is emitted on the next cycle.
// A match alternates one window read and one write/emit per byte, set by
// the single read and single write port of the history RAM; a read waits while the output is held.
// Reset is immediate: the window reads as 0x20 until written (fill tracking).
// ----------------------------------------------------------------------------
module lzss_window_decompressor
	import lzwd_pkg::*;
#(
	parameter int MIN_MATCH = MIN_MATCH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lzwd_in_if.sink     comp,
	lzwd_out_if.source  plain
);

	localparam int CNT_W = $clog2(15 + MIN_MATCH);

	lzwd_state_t state_q, state_d;

	pos_t                  wp_q;
	logic                  wrapped_q;
	byte_t                 flag_bits_q;
	logic [FLAG_CNT_W-1:0] flags_left_q;
	byte_t                 first_q;
	logic                  have_first_q;
	pos_t                  src_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  hit_s1;

	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	logic  out_free;
	logic  accept;
	logic  is_flag, is_lit, is_first, is_second;
	logic  rd_go;
	logic  mem_we;
	pos_t  mem_raddr;
	byte_t mem_wdata;
	byte_t mem_rdata;
	byte_t copy_byte;
	logic  load_out;
	logic  load_last;

	assign out_free = !out_valid_q || plain.ready;
	assign comp.ready = (state_q == ST_IDLE) && out_free;
	assign accept = comp.valid && comp.ready;

	assign is_flag   = (flags_left_q == '0);
	assign is_lit    = !is_flag && flag_bits_q[0];
	assign is_first  = !is_flag && !flag_bits_q[0] && !have_first_q;
	assign is_second = !is_flag && !flag_bits_q[0] && have_first_q;

	// unwritten entries read as the fill byte
	assign copy_byte = hit_s1 ? mem_rdata : SPACE_FILL;

	lzwd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW_SIZE)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_second) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (out_free) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				state_d = (cnt_q == '0) ? ST_IDLE : ST_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_go     = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = comp.in_byte;
		mem_raddr = src_q;
		load_out  = 1'b0;
		load_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_lit) begin
					mem_we   = 1'b1;
					load_out = 1'b1;
				end
			end
			ST_RD: begin
				rd_go = out_free;
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_wdata = copy_byte;
				load_out  = 1'b1;
				load_last = (cnt_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			have_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (mem_we) begin
				wp_q <= wp_q + POS_W'(1);
				if (wp_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end

			if (accept) begin
				if (is_flag) begin
					flag_bits_q  <= comp.in_byte;
					flags_left_q <= FLAGS_PER_BYTE;
				end else if (is_first) begin
					have_first_q <= 1'b1;
				end else begin
					flag_bits_q  <= flag_bits_q >> 1;
					flags_left_q <= flags_left_q - FLAG_CNT_W'(1);
					have_first_q <= 1'b0;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (plain.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept && is_first) begin
			first_q <= comp.in_byte;
		end
		if (accept && is_second) begin
			// distance zero wraps to a full window back, i.e. src == wp
			src_q <= wp_q - {comp.in_byte[7:4], first_q};
			cnt_q <= CNT_W'(comp.in_byte[3:0]) + CNT_W'(MIN_MATCH - 1);
		end else if (state_q == ST_WR) begin
			src_q <= src_q + POS_W'(1);
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (rd_go) begin
			hit_s1 <= wrapped_q || (src_q < wp_q);
		end
		if (load_out) begin
			out_byte_q <= mem_wdata;
			out_last_q <= load_last;
		end
	end

	assign plain.valid    = out_valid_q;
	assign plain.out_byte = out_byte_q;
	assign plain.out_last = out_last_q;

endmodule

// ===== test/tb_lzss_window_decompressor.sv =====
// ----------------------------------------------------------------------------
// tb_lzss_window_decompressor
// Self-checking bench for the LZSS decoder. A local decoder model tracks the
// window and flag state, predicts every plain byte with its last marker, and
// a monitor checks each output transaction in order. Directed literal and
// match cases run first, then a biased random stream and a long-match run
// that wraps the window. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_lzss_window_decompressor;
	import lzwd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 50;

	typedef struct packed {
		byte_t data;
		logic  last;
	} plain_beat_t;

	logic clk;
	logic arst_n;

	lzwd_in_if  comp_if ();
	lzwd_out_if plain_if ();

	lzss_window_decompressor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.comp   (comp_if),
		.plain  (plain_if)
	);

	// decoder model state
	byte_t                 win_mem [WINDOW_SIZE];
	pos_t                  wr_ptr;
	byte_t                 flag_reg;
	logic [FLAG_CNT_W-1:0] flags_pending;
	byte_t                 match_lo;
	logic                  match_lo_valid;
	int                    emitted_count;

	plain_beat_t plain_bytes_due [$];
	int          error_count;
	int          quiet_cycles;
	int          stall_left;
	bit          gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_decoder_model();
		foreach (win_mem[i]) win_mem[i] = SPACE_FILL;
		wr_ptr         = '0;
		flag_reg       = '0;
		flags_pending  = '0;
		match_lo       = '0;
		match_lo_valid = 1'b0;
		emitted_count  = 0;
	endfunction

	function automatic void decode_compressed_byte(input byte_t b);
		int unsigned len;
		pos_t        back;
		pos_t        src;
		byte_t       v;
		if (flags_pending == '0) begin
			flag_reg      = b;
			flags_pending = FLAGS_PER_BYTE;
		end else if (flag_reg[0]) begin
			win_mem[wr_ptr] = b;
			wr_ptr          = wr_ptr + POS_W'(1);
			flag_reg        = flag_reg >> 1;
			flags_pending   = flags_pending - FLAG_CNT_W'(1);
			plain_bytes_due.push_back('{data: b, last: 1'b1});
			emitted_count++;
		end else if (!match_lo_valid) begin
			match_lo       = b;
			match_lo_valid = 1'b1;
		end else begin
			len  = int'(b[3:0]) + MIN_MATCH_DEF;
			back = {b[7:4], match_lo};
			// 12-bit pointer math: distance zero points at the slot itself,
			// which is the same slot as a full window back
			for (int unsigned i = 0; i < len; i++) begin
				src             = wr_ptr - back;
				v               = win_mem[src];
				win_mem[wr_ptr] = v;
				wr_ptr          = wr_ptr + POS_W'(1);
				plain_bytes_due.push_back('{data: v, last: (i == len - 1)});
				emitted_count++;
			end
			match_lo       = '0;
			match_lo_valid = 1'b0;
			flag_reg       = flag_reg >> 1;
			flags_pending  = flags_pending - FLAG_CNT_W'(1);
		end
	endfunction

	// Picks the next byte from the decoder state so most of the stream is
	// well formed; long_only forces full-length matches.
	function automatic byte_t pick_byte(input bit long_only);
		byte_t b;
		b = byte_t'($urandom);
		if (!long_only && $urandom_range(0, 9) == 0)
			return b;
		if (flags_pending == '0) begin
			if (long_only || $urandom_range(0, 1) == 0)
				b = 8'h00;
			else if ($urandom_range(0, 4) == 0)
				b = 8'hFF;
		end else if (!flag_reg[0] && !match_lo_valid) begin
			if (!long_only && $urandom_range(0, 3) == 0)
				b = byte_t'($urandom_range(0, 4));
		end else if (!flag_reg[0]) begin
			if (long_only || $urandom_range(0, 1) == 0)
				b[3:0] = 4'hF;
			// short distances copy over the bytes being written
			if (match_lo < 8'd5 && $urandom_range(0, 1) == 0)
				b[7:4] = 4'h0;
		end
		return b;
	endfunction

	task automatic send_byte(input byte_t b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			comp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		comp_if.valid   <= 1'b1;
		comp_if.in_byte <= b;
		@(posedge clk);
		while (!comp_if.ready) @(posedge clk);
		decode_compressed_byte(b);
	endtask

	task automatic hold_until_drained();
		comp_if.valid <= 1'b0;
		@(posedge clk);
		while (plain_bytes_due.size() != 0) @(posedge clk);
	endtask

	task automatic send_match(input byte_t lo, input byte_t hi);
		send_byte(lo);
		send_byte(hi);
	endtask

	task automatic test_literal_extremes();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFE);
	endtask

	task automatic test_match_cases();
		send_byte(8'h00);
		send_match(8'h00, 8'h00);   // distance zero: slot copied onto itself
		send_match(8'h0B, 8'h0F);   // max length, overlaps its own output
		send_match(8'h01, 8'h00);   // distance one, run of the last byte
		send_match(8'hFF, 8'hF5);   // max distance, untouched 0x20 fill
		send_match(8'h02, 8'h01);
		send_match(8'h03, 8'h02);
		send_match(8'h00, 8'h80);   // half window back, wraps below zero
		send_match(8'hF0, 8'h0E);
	endtask

	task automatic test_random_stream(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			gaps_on = !(i >= 40 && i < 70);
			if (i == n_items / 2)
				hold_until_drained();
			send_byte(pick_byte(1'b0));
		end
	endtask

	// Long matches until the write pointer has gone around the window.
	task automatic test_window_wrap();
		gaps_on = 1'b0;
		while (emitted_count < WINDOW_SIZE + 32)
			send_byte(pick_byte(1'b1));
	endtask

	// sink side: stall bursts, with ready high again between bursts
	initial begin
		plain_if.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (gaps_on && stall_left == 0 && plain_if.ready && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left != 0) begin
				plain_if.ready <= 1'b0;
				stall_left--;
			end else begin
				plain_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : plain_check
		plain_beat_t want;
		if (arst_n && plain_if.valid && plain_if.ready) begin
			if (plain_bytes_due.size() == 0) begin
				$error("unexpected plain transaction: out_byte %02h, out_last %0b",
					plain_if.out_byte, plain_if.out_last);
				error_count++;
			end else begin
				want = plain_bytes_due.pop_front();
				if (plain_if.out_byte !== want.data) begin
					$error("out_byte: expected %02h, actual %02h", want.data, plain_if.out_byte);
					error_count++;
				end
				if (plain_if.out_last !== want.last) begin
					$error("out_last: expected %0b, actual %0b", want.last, plain_if.out_last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((comp_if.valid && comp_if.ready) || (plain_if.valid && plain_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		quiet_cycles = 0;
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("lzss_window_decompressor verification failed");
		$finish;
	end

	initial begin
		error_count = 0;
		gaps_on     = 1'b1;
		arst_n          <= 1'b0;
		comp_if.valid   <= 1'b0;
		comp_if.in_byte <= '0;
		reset_decoder_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_literal_extremes();
		test_match_cases();
		test_random_stream(100);
		test_window_wrap();

		comp_if.valid <= 1'b0;
		@(posedge clk);
		while (plain_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (plain_bytes_due.size() != 0) begin
			$error("%0d plain bytes never arrived", plain_bytes_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("lzss_window_decompressor verification clean");
		else
			$display("lzss_window_decompressor verification failed");
		$finish;
	end

endmodule
